// ----- rtl/xorshift64_rng_splitmix_seeded_core_assert.svh -----
// Assertion macros used by the generator sequencer.
// Each macro checks one implication on the rising clock edge, with reset masking the check.
`ifndef XORSHIFT64_RNG_SPLITMIX_SEEDED_CORE_ASSERT_SVH
`define XORSHIFT64_RNG_SPLITMIX_SEEDED_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define XRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xrs assertion failed");

// Next-cycle implication.
`define XRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xrs assertion failed");

`else

`define XRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define XRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/xrs_pkg.sv -----
package xrs_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    localparam int MIX_SHIFT_1 = 30;
    localparam int MIX_SHIFT_2 = 27;
    localparam int MIX_SHIFT_3 = 31;
    localparam int XS_SHIFT_A  = 13;
    localparam int XS_SHIFT_B  = 7;
    localparam int XS_SHIFT_C  = 17;

    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LL,
        S_MUL_HL,
        S_MUL_LH,
        S_MIX2,
        S_FINISH
    } t_ctrl_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADVANCE,
        OP_SEED_ADD,
        OP_MUL_LL,
        OP_MUL_HL,
        OP_MUL_LH,
        OP_MIX2,
        OP_FINISH
    } t_dp_op;

    // sel_b picks the second mixing multiplier constant.
    typedef struct packed {
        t_dp_op op;
        logic   sel_b;
    } t_dp_cmd;

endpackage

// ----- rtl/xrs_datapath.sv -----
module xrs_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xrs_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]      i_seed_value,
    output logic [63:0]      o_random_word
);
    import xrs_pkg::*;

    logic [63:0] r_state;
    logic [63:0] n_state;
    logic [63:0] r_out;
    logic [63:0] n_out;
    logic [63:0] r_z;
    logic [63:0] n_z;
    logic [63:0] r_acc;
    logic [63:0] n_acc;

    logic [63:0] w_const;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_sum;
    logic [63:0] w_x1;
    logic [63:0] w_x2;
    logic [63:0] w_adv;
    logic [63:0] w_fin;

    assign w_const = i_cmd.sel_b ? MIX_MUL_B : MIX_MUL_A;
    assign w_sum   = i_seed_value + GOLDEN_GAMMA;

    // One xorshift64 step on the stored state.
    assign w_x1  = r_state ^ (r_state << XS_SHIFT_A);
    assign w_x2  = w_x1 ^ (w_x1 >> XS_SHIFT_B);
    assign w_adv = w_x2 ^ (w_x2 << XS_SHIFT_C);

    assign w_fin = r_acc ^ (r_acc >> MIX_SHIFT_3);

    // The 64-bit product modulo 2^64 is built from three 32x32 partial products.
    always_comb begin
        case (i_cmd.op)
            OP_MUL_HL: begin
                w_mul_a = r_z[63:32];
                w_mul_b = w_const[31:0];
            end
            OP_MUL_LH: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[63:32];
            end
            default: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[31:0];
            end
        endcase
    end

    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_z     = r_z;
        n_acc   = r_acc;
        case (i_cmd.op)
            OP_ADVANCE: begin
                n_state = w_adv;
                n_out   = w_adv;
            end
            OP_SEED_ADD: begin
                n_z = w_sum ^ (w_sum >> MIX_SHIFT_1);
            end
            OP_MUL_LL: begin
                n_acc = w_prod;
            end
            OP_MUL_HL, OP_MUL_LH: begin
                n_acc = r_acc + {w_prod[31:0], 32'd0};
            end
            OP_MIX2: begin
                n_z = r_acc ^ (r_acc >> MIX_SHIFT_2);
            end
            OP_FINISH: begin
                n_state = w_fin;
                n_out   = w_fin;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_z   <= n_z;
        r_acc <= n_acc;
    end

    assign o_random_word = r_out;

endmodule

// ----- rtl/xrs_ctrl.sv -----
`include "xorshift64_rng_splitmix_seeded_core_assert.svh"

module xrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output xrs_pkg::t_dp_cmd  o_cmd
);
    import xrs_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_pass;
    logic        n_pass;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        w_slot_free;
    logic        w_accept;
    logic        w_out_load;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_out_load = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.sel_b = r_pass;
        case (r_state)
            S_IDLE: begin
                // A seed request may start while a result still waits, since it
                // only needs the output slot at its last step.
                o_in_stall = (i_func == FUNC_NEXT) ? !w_slot_free : 1'b0;
                w_accept   = i_in_valid && !o_in_stall;
                if (w_accept) begin
                    if (i_func == FUNC_NEXT) begin
                        o_cmd.op   = OP_ADVANCE;
                        w_out_load = 1'b1;
                    end else begin
                        o_cmd.op = OP_SEED_ADD;
                        n_pass   = 1'b0;
                        n_state  = S_MUL_LL;
                    end
                end
            end
            S_MUL_LL: begin
                o_cmd.op = OP_MUL_LL;
                n_state  = S_MUL_HL;
            end
            S_MUL_HL: begin
                o_cmd.op = OP_MUL_HL;
                n_state  = S_MUL_LH;
            end
            S_MUL_LH: begin
                o_cmd.op = OP_MUL_LH;
                n_state  = r_pass ? S_FINISH : S_MIX2;
            end
            S_MIX2: begin
                o_cmd.op = OP_MIX2;
                n_pass   = 1'b1;
                n_state  = S_MUL_LL;
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.op   = OP_FINISH;
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = w_out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `XRS_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `XRS_ASSERT_NEXT(a_next_gives_result, i_clk, i_rst_n, w_accept && i_func == FUNC_NEXT, r_out_valid)
    `XRS_ASSERT_NEXT(a_seed_starts_mul, i_clk, i_rst_n, w_accept && i_func == FUNC_SEED, r_state == S_MUL_LL && !r_pass)
    `XRS_ASSERT_NEXT(a_first_pass_mixes, i_clk, i_rst_n, r_state == S_MUL_LH && !r_pass, r_state == S_MIX2)
    `XRS_ASSERT_NEXT(a_finish_waits, i_clk, i_rst_n, r_state == S_FINISH && !w_slot_free, r_state == S_FINISH && r_out_valid)

endmodule

// ----- rtl/xorshift64_rng_splitmix_seeded_core.sv -----
// xorshift64 random word generator with splitmix64 seeding.
// Input channel: i_in_valid / o_in_stall carry a request of i_func and
// i_seed_value. i_func = 0 seeds the generator, i_func = 1 asks for the next word.
// Output channel: o_out_valid / i_out_stall carry o_random_word, the new state.
// Every request gives exactly one result, in request order.
// For a next request, the xorshift step is computed from the state
// register and lands in the output register at the accepting edge. Back-to-back
// next requests run at one per cycle while the receiver takes results.
// A seed request stalls the input from its acceptance until its final step
// writes the output register. The two splitmix multiplies by 64-bit constants
// each take three passes through one shared 32x32 multiplier, plus one add
// step, one mix step and one final step that writes the output register.
// The output register holds one result. When it is full and stalled, next
// requests are stalled; a seed request is still taken and waits at its last
// step until the slot frees. A stalled result holds its value.
// Synchronous active-low reset clears the state to zero, so next requests
// before any seed return zero, and empties the output register.
module xorshift64_rng_splitmix_seeded_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [63:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_random_word
);
    import xrs_pkg::*;

    // Command word from the sequencer to the arithmetic datapath.
    t_dp_cmd w_cmd;

    xrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    xrs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_seed_value  (i_seed_value),
        .o_random_word (o_random_word)
    );

endmodule

// ----- tb/sv/tb_xorshift64_rng_splitmix_seeded_core.sv -----
`timescale 1ns / 1ps

module tb_xorshift64_rng_splitmix_seeded_core;
    import xrs_pkg::*;

    // Mixing constants of the seeding round; the shift amounts sit as literals in
    // the scoreboard functions. All are kept local so that the prediction does not
    // lean on anything inside the design.
    localparam bit [63:0] SEED_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam bit [63:0] SEED_MUL_1 = 64'hBF58_476D_1CE4_E5B9;
    localparam bit [63:0] SEED_MUL_2 = 64'h94D0_49BB_1331_11EB;

    // A seed that cancels the golden-ratio add, so the mixed state is zero.
    localparam bit [63:0] ZERO_MIX_SEED = 64'h0 - SEED_GAMMA;

    localparam int RANDOM_REQUESTS = 2000;
    localparam int DRAIN_CYCLES    = 16;

    // Scoreboard: it keeps its own copy of the generator state, works out the
    // word that every accepted request must give, and matches the words that
    // come out against those predictions in order.
    class rng_scoreboard;
        bit [63:0] gen_state;
        bit [63:0] expected_words[$];
        int        err_count;

        function new();
            gen_state = '0;
            err_count = 0;
        endfunction

        function bit [63:0] splitmix_round(bit [63:0] seed);
            bit [63:0] z;
            z = seed + SEED_GAMMA;
            z = (z ^ (z >> 30)) * SEED_MUL_1;
            z = (z ^ (z >> 27)) * SEED_MUL_2;
            return z ^ (z >> 31);
        endfunction

        function bit [63:0] xorshift_step(bit [63:0] x);
            x = x ^ (x << 13);
            x = x ^ (x >> 7);
            x = x ^ (x << 17);
            return x;
        endfunction

        // Called once for each accepted request.
        function void note_request(logic func, logic [63:0] seed);
            if (func == FUNC_SEED) begin
                gen_state = splitmix_round(seed);
            end else begin
                gen_state = xorshift_step(gen_state);
            end
            expected_words.push_back(gen_state);
        endfunction

        task report_mismatch(string what, bit [63:0] got, bit [63:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
            err_count++;
        endtask

        // Called once for each accepted result.
        task check_word(logic [63:0] word);
            bit [63:0] want;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected result", word, '0);
            end else begin
                want = expected_words.pop_front();
                if (word !== want) begin
                    report_mismatch("random_word", word, want);
                end
            end
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // Every input of the block starts at a known value, with reset held.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_func       = FUNC_NEXT;
    logic [63:0] i_seed_value = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_random_word;

    rng_scoreboard board = new();

    xorshift64_rng_splitmix_seeded_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_seed_value  (i_seed_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Present one request and hold it until the block takes it. All inputs
    // change with nonblocking assignments at the rising edge, and the stall is
    // read right after the edge, so it still shows its value from before the
    // edge; a request counts as taken when that value was low.
    task send_request(input logic func, input logic [63:0] seed);
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        board.note_request(func, seed);
    endtask

    // A gap in the request stream. The payload wanders while valid is low so
    // that the block is seen to ignore it.
    task idle_sender(input int cycles);
        repeat (cycles) begin
            i_in_valid   <= 1'b0;
            i_func       <= 1'($urandom);
            i_seed_value <= {$urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted word has come out. At least
    // one edge always passes, so valid is never lowered and raised again in
    // the same time step.
    task drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (board.pending() != 0);
    endtask

    // Receiver side: results are checked when valid was high and stall low
    // before the edge. The stall then follows a pattern of its own: runs of
    // free cycles, short stalls, and now and then a long one, so that stalls
    // land on every step of a seed request as well as on streams of next
    // requests.
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_word(o_random_word);
        end
        if (stall_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    i_out_stall <= 1'b0;
                    stall_left  <= $urandom_range(1, 30);
                end
                4, 5, 6, 7: begin
                    i_out_stall <= 1'b1;
                    stall_left  <= $urandom_range(1, 4);
                end
                8: begin
                    i_out_stall <= 1'b1;
                    stall_left  <= $urandom_range(10, 40);
                end
                default: begin
                    // Flicker: one random stall value, then a new choice of pattern.
                    i_out_stall <= 1'($urandom);
                    stall_left  <= 1;
                end
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // Main sequence.
    int sent;
    int burst;
    int gap;
    logic        rnd_func;
    logic [63:0] rnd_seed;

    initial begin
        // Reset is held at the start and then released for good.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Next requests before any seed must give zero,
        // whatever the seed value says.
        send_request(FUNC_NEXT, 64'h0);
        send_request(FUNC_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);

        // Extremes of the seed value.
        send_request(FUNC_SEED, 64'h0);
        send_request(FUNC_NEXT, 64'h0);
        send_request(FUNC_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_SEED, 64'h8000_0000_0000_0000);
        send_request(FUNC_SEED, 64'h0000_0000_0000_0001);

        // A seed that mixes to zero: the zero state is kept and then stays
        // zero under the next requests that follow.
        send_request(FUNC_SEED, ZERO_MIX_SEED);
        send_request(FUNC_NEXT, 64'h5555_5555_5555_5555);
        send_request(FUNC_NEXT, 64'hAAAA_AAAA_AAAA_AAAA);

        // Reseed out of the zero state, with alternating bit patterns.
        send_request(FUNC_SEED, 64'h5555_5555_5555_5555);
        send_request(FUNC_NEXT, 64'h0);
        send_request(FUNC_SEED, 64'hAAAA_AAAA_AAAA_AAAA);

        // Back-to-back seeds, then a run of next requests with a gap.
        send_request(FUNC_SEED, 64'h0123_4567_89AB_CDEF);
        send_request(FUNC_SEED, 64'hFEDC_BA98_7654_3210);
        send_request(FUNC_NEXT, 64'h1234_5678_9ABC_DEF0);
        send_request(FUNC_NEXT, 64'h0);
        idle_sender(3);
        send_request(FUNC_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_NEXT, 64'h0);

        // Random part: bursts of requests, mostly next requests with a seed
        // now and then, separated by random gaps or none at all.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                rnd_func = ($urandom_range(0, 9) == 0) ? FUNC_SEED : FUNC_NEXT;
                case ($urandom_range(0, 31))
                    0:       rnd_seed = 64'h0;
                    1:       rnd_seed = 64'hFFFF_FFFF_FFFF_FFFF;
                    2:       rnd_seed = ZERO_MIX_SEED;
                    default: rnd_seed = {$urandom, $urandom};
                endcase
                send_request(rnd_func, rnd_seed);
                sent++;
                // Halfway through, hold the sender until all words are out.
                if (sent == RANDOM_REQUESTS / 2) begin
                    drain_results();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            idle_sender(gap);
        end

        // Wind down: wait for the last words, then keep watching the output to catch
        // anything stray that comes after them.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.err_count == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 2000 requests
    // with long gaps and long receiver stalls.
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- xorshift64_rng_splitmix_seeded_core.f -----
+incdir+rtl
rtl/xrs_pkg.sv
rtl/xrs_datapath.sv
rtl/xrs_ctrl.sv
rtl/xorshift64_rng_splitmix_seeded_core.sv
tb/sv/tb_xorshift64_rng_splitmix_seeded_core.sv
